// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of the block.
// Standalone header; the including file supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock, disabled while reset is low.
`define AFC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the block clock and reset.
`define AFC_CHECK(label, prop, msg) `AFC_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== src/afc_pkg.sv =====
// Shared types, constants and width helpers for the aspect-fit block.
// No dependencies; every other file but assert_macros.svh imports this package.
`timescale 1ns / 1ps

package afc_pkg;

  localparam int FIELD_W      = 16;  // width of every dimension port
  localparam int DIM_BITS_DEF = 16;  // default dimension width
  localparam int MODE_W       = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int PIPE_EXTRA   = 4;   // cycles beyond the divider steps

  typedef enum logic [MODE_W-1:0] {
    MODE_CLIP,   // unscaled: centre and clip
    MODE_BAD,    // scaling with a zero dimension
    MODE_EQUAL,  // ratios match: whole destination
    MODE_FIT_W,  // source wider: fill width, letterbox
    MODE_FIT_H   // source taller: fill height, pillarbox
  } afc_mode_e;

  typedef struct packed {
    logic full;
    logic empty;
  } afc_qstat_t;

  // Effective dimension width: never wider than the ports.
  function automatic int afc_dim_w(int bits);
    return (bits < FIELD_W) ? bits : FIELD_W;
  endfunction

  // Job word: mode, numerator, divisor, dw, dh, clipped w, clipped h.
  function automatic int afc_job_w(int dim_w);
    return MODE_W + 7 * dim_w;
  endfunction

  function automatic int afc_latency(int dim_w);
    return dim_w + PIPE_EXTRA;
  endfunction

endpackage

// ===== src/afc_front.sv =====
// Front end: accepts an item, forms the cross products and classifies it.
// Depends on afc_pkg; pushes one job word per item into afc_queue.
`timescale 1ns / 1ps

module afc_front #(
  parameter int DIM_W = afc_pkg::FIELD_W,
  parameter int JOB_W = afc_pkg::afc_job_w(afc_pkg::FIELD_W)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [DIM_W-1:0]    src_w_i,
  input  logic [DIM_W-1:0]    src_h_i,
  input  logic [DIM_W-1:0]    dst_w_i,
  input  logic [DIM_W-1:0]    dst_h_i,
  input  logic                scale_mode_i,
  input  afc_pkg::afc_qstat_t qstat_i,
  output logic                push_o,
  output logic [JOB_W-1:0]    job_o
);
  import afc_pkg::*;

  localparam int PROD_W = 2 * DIM_W;

  logic              v1_q;
  logic              stall;
  logic              accept;
  logic [DIM_W-1:0]  sw_q, sh_q, dw_q, dh_q;
  logic              scale_q;
  logic [PROD_W-1:0] lhs_q, rhs_q;

  afc_mode_e         mode;
  logic [PROD_W-1:0] num;
  logic [DIM_W-1:0]  den, cw, ch;
  logic              any_zero;
  logic              src_wider;

  assign stall  = v1_q && qstat_i.full;
  assign busy_o = stall;
  assign accept = start_i && !stall;
  assign push_o = v1_q && !qstat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!stall) begin
      v1_q <= start_i;
    end
  end

  // Capture dims and both cross products in the accept cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sw_q    <= src_w_i;
      sh_q    <= src_h_i;
      dw_q    <= dst_w_i;
      dh_q    <= dst_h_i;
      scale_q <= scale_mode_i;
      lhs_q   <= PROD_W'(src_w_i) * PROD_W'(dst_h_i);
      rhs_q   <= PROD_W'(dst_w_i) * PROD_W'(src_h_i);
    end
  end

  always_comb begin
    any_zero  = (sw_q == '0) || (sh_q == '0) || (dw_q == '0) || (dh_q == '0);
    src_wider = lhs_q > rhs_q;
    if (!scale_q) begin
      mode = MODE_CLIP;
    end else if (any_zero) begin
      mode = MODE_BAD;
    end else if (src_wider) begin
      mode = MODE_FIT_W;
    end else if (lhs_q < rhs_q) begin
      mode = MODE_FIT_H;
    end else begin
      mode = MODE_EQUAL;
    end
    num = src_wider ? rhs_q : lhs_q;
    den = src_wider ? sw_q : sh_q;
    cw  = (sw_q < dw_q) ? sw_q : dw_q;
    ch  = (sh_q < dh_q) ? sh_q : dh_q;
  end

  assign job_o = {mode, num, den, dw_q, dh_q, cw, ch};

endmodule

// ===== src/afc_queue.sv =====
// Short FIFO of job words between the front end and the divider.
// Depends on afc_pkg for the status struct and default depth.
`timescale 1ns / 1ps

module afc_queue #(
  parameter int WIDTH = afc_pkg::afc_job_w(afc_pkg::FIELD_W),
  parameter int DEPTH = afc_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    data_o,
  output afc_pkg::afc_qstat_t stat_o
);
  import afc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/afc_back.sv =====
// Back end: restoring divider, one quotient bit per stage, then placement.
// Depends on afc_pkg; drains afc_queue one job word per cycle.
`timescale 1ns / 1ps

module afc_back #(
  parameter int DIM_W = afc_pkg::FIELD_W,
  parameter int JOB_W = afc_pkg::afc_job_w(afc_pkg::FIELD_W)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afc_pkg::afc_qstat_t qstat_i,
  input  logic [JOB_W-1:0]    job_i,
  output logic                pop_o,
  output logic                valid_o,
  output logic [DIM_W-1:0]    pos_x_o,
  output logic [DIM_W-1:0]    pos_y_o,
  output logic [DIM_W-1:0]    out_w_o,
  output logic [DIM_W-1:0]    out_h_o,
  output logic                bad_size_o
);
  import afc_pkg::*;

  localparam int PROD_W = 2 * DIM_W;
  localparam int NSTG   = DIM_W + 1;

  logic [MODE_W-1:0] j_mode_raw;
  afc_mode_e         j_mode;
  logic [PROD_W-1:0] j_num;
  logic [DIM_W-1:0]  j_den, j_dw, j_dh, j_cw, j_ch;

  logic [NSTG-1:0]   vld_q;
  afc_mode_e         mode_q [NSTG];
  logic [DIM_W-1:0]  den_q  [NSTG];
  logic [DIM_W-1:0]  dw_q   [NSTG];
  logic [DIM_W-1:0]  dh_q   [NSTG];
  logic [DIM_W-1:0]  cw_q   [NSTG];
  logic [DIM_W-1:0]  ch_q   [NSTG];
  logic [DIM_W-1:0]  rem_q  [NSTG];
  logic [DIM_W-1:0]  low_q  [NSTG];
  logic [DIM_W-1:0]  quo_q  [NSTG];

  logic [DIM_W-1:0]  rem_n  [DIM_W];
  logic [DIM_W-1:0]  quo_n  [DIM_W];
  logic [DIM_W:0]    trial  [DIM_W];
  logic [DIM_W:0]    diff   [DIM_W];

  logic              out_vld_q;
  logic [DIM_W-1:0]  px_d, py_d, ow_d, oh_d;
  logic              bad_d;
  logic [DIM_W-1:0]  spare_x, spare_y, q_fin;

  assign pop_o = !qstat_i.empty;

  assign {j_mode_raw, j_num, j_den, j_dw, j_dh, j_cw, j_ch} = job_i;
  assign j_mode = afc_mode_e'(j_mode_raw);

  // One compare-subtract per stage on the partial remainder.
  always_comb begin
    for (int i = 0; i < DIM_W; i++) begin
      trial[i] = {rem_q[i], low_q[i][DIM_W-1]};
      diff[i]  = trial[i] - {1'b0, den_q[i]};
      if (trial[i] >= {1'b0, den_q[i]}) begin
        rem_n[i] = diff[i][DIM_W-1:0];
        quo_n[i] = {quo_q[i][DIM_W-2:0], 1'b1};
      end else begin
        rem_n[i] = trial[i][DIM_W-1:0];
        quo_n[i] = {quo_q[i][DIM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[NSTG-2:0], pop_o};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q[0] <= j_mode;
    den_q[0]  <= j_den;
    dw_q[0]   <= j_dw;
    dh_q[0]   <= j_dh;
    cw_q[0]   <= j_cw;
    ch_q[0]   <= j_ch;
    rem_q[0]  <= j_num[PROD_W-1:DIM_W];
    low_q[0]  <= j_num[DIM_W-1:0];
    quo_q[0]  <= '0;
    for (int i = 0; i < DIM_W; i++) begin
      mode_q[i+1] <= mode_q[i];
      den_q[i+1]  <= den_q[i];
      dw_q[i+1]   <= dw_q[i];
      dh_q[i+1]   <= dh_q[i];
      cw_q[i+1]   <= cw_q[i];
      ch_q[i+1]   <= ch_q[i];
      rem_q[i+1]  <= rem_n[i];
      low_q[i+1]  <= {low_q[i][DIM_W-2:0], 1'b0};
      quo_q[i+1]  <= quo_n[i];
    end
  end

  // Place the rectangle by mode, using the finished quotient in the fit modes.
  always_comb begin
    q_fin   = quo_q[DIM_W];
    spare_x = '0;
    spare_y = '0;
    px_d    = '0;
    py_d    = '0;
    ow_d    = '0;
    oh_d    = '0;
    bad_d   = 1'b0;
    unique case (mode_q[DIM_W])
      MODE_CLIP: begin
        spare_x = dw_q[DIM_W] - cw_q[DIM_W];
        spare_y = dh_q[DIM_W] - ch_q[DIM_W];
        ow_d    = cw_q[DIM_W];
        oh_d    = ch_q[DIM_W];
        px_d    = spare_x >> 1;
        py_d    = spare_y >> 1;
      end
      MODE_BAD: begin
        bad_d = 1'b1;
      end
      MODE_EQUAL: begin
        ow_d = dw_q[DIM_W];
        oh_d = dh_q[DIM_W];
      end
      MODE_FIT_W: begin
        spare_y = dh_q[DIM_W] - q_fin;
        ow_d    = dw_q[DIM_W];
        oh_d    = q_fin;
        py_d    = spare_y >> 1;
      end
      MODE_FIT_H: begin
        spare_x = dw_q[DIM_W] - q_fin;
        ow_d    = q_fin;
        oh_d    = dh_q[DIM_W];
        px_d    = spare_x >> 1;
      end
      default: begin
        bad_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_x_o    <= px_d;
    pos_y_o    <= py_d;
    out_w_o    <= ow_d;
    out_h_o    <= oh_d;
    bad_size_o <= bad_d;
  end

  assign valid_o = out_vld_q;

endmodule

// ===== src/aspect_fit_center_rect_core.sv =====
// An accepted item passes the front register, the job queue, the DIM_W-stage divider
// and the output register before its result strobe (DIM_W = min(DIM_BITS, 16)).
// Throughput: one item per cycle; the divider drains the job queue every cycle,
// so the queue never holds more than one word and busy never rises.
// The result is shown for one cycle under valid_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears all valid bits and the queue pointers.
`timescale 1ns / 1ps

module aspect_fit_center_rect_core #(
  parameter int DIM_BITS = afc_pkg::DIM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [afc_pkg::FIELD_W-1:0]   src_w_i,
  input  logic [afc_pkg::FIELD_W-1:0]   src_h_i,
  input  logic [afc_pkg::FIELD_W-1:0]   dst_w_i,
  input  logic [afc_pkg::FIELD_W-1:0]   dst_h_i,
  input  logic                          scale_mode_i,
  output logic                          valid_o,
  output logic [afc_pkg::FIELD_W-1:0]   pos_x_o,
  output logic [afc_pkg::FIELD_W-1:0]   pos_y_o,
  output logic [afc_pkg::FIELD_W-1:0]   out_w_o,
  output logic [afc_pkg::FIELD_W-1:0]   out_h_o,
  output logic                          bad_size_o
);
  import afc_pkg::*;

  // Dimensions are cut to DIM_BITS; the ports already bound them at 16 bits.
  localparam int DIM_W = afc_dim_w(DIM_BITS);
  localparam int JOB_W = afc_job_w(DIM_W);

  afc_qstat_t       qstat;
  logic             push, pop;
  logic [JOB_W-1:0] job_in, job_out;
  logic [DIM_W-1:0] px, py, ow, oh;

  // Front: take the beat, form sw*dh and dw*sh, classify into a job word.
  afc_front #(
    .DIM_W (DIM_W),
    .JOB_W (JOB_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .src_w_i      (src_w_i[DIM_W-1:0]),
    .src_h_i      (src_h_i[DIM_W-1:0]),
    .dst_w_i      (dst_w_i[DIM_W-1:0]),
    .dst_h_i      (dst_h_i[DIM_W-1:0]),
    .scale_mode_i (scale_mode_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .job_o        (job_in)
  );

  // Queue: decouple classification from the divider pipeline.
  afc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .stat_o (qstat)
  );

  // Back: floor-divide the chosen cross product, then centre the result.
  afc_back #(
    .DIM_W (DIM_W),
    .JOB_W (JOB_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .job_i      (job_out),
    .pop_o      (pop),
    .valid_o    (valid_o),
    .pos_x_o    (px),
    .pos_y_o    (py),
    .out_w_o    (ow),
    .out_h_o    (oh),
    .bad_size_o (bad_size_o)
  );

  // Zero-extend the placed rectangle back to port width.
  assign pos_x_o = FIELD_W'(px);
  assign pos_y_o = FIELD_W'(py);
  assign out_w_o = FIELD_W'(ow);
  assign out_h_o = FIELD_W'(oh);

endmodule

// ===== src/afc_checker.sv =====
// Port-level checks on the aspect-fit core: timing, error-result form and field widths.
// Depends on afc_pkg and assert_macros.svh; bound to the top level below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module afc_checker #(
  parameter int DIM_BITS = afc_pkg::DIM_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_i,
  input logic                        valid_i,
  input logic [afc_pkg::FIELD_W-1:0] pos_x_i,
  input logic [afc_pkg::FIELD_W-1:0] pos_y_i,
  input logic [afc_pkg::FIELD_W-1:0] out_w_i,
  input logic [afc_pkg::FIELD_W-1:0] out_h_i,
  input logic                        bad_size_i
);
  import afc_pkg::*;

  localparam int DIM_W = afc_dim_w(DIM_BITS);
  localparam int LAT   = afc_latency(DIM_W);

  logic rect_zero;
  logic rect_fits;

  assign rect_zero = (pos_x_i == '0) && (pos_y_i == '0) && (out_w_i == '0) && (out_h_i == '0);
  assign rect_fits = ((pos_x_i >> DIM_W) == '0) && ((pos_y_i >> DIM_W) == '0) &&
                     ((out_w_i >> DIM_W) == '0) && ((out_h_i >> DIM_W) == '0);

  `AFC_CHECK(a_beat_gives_result, (start_i && !busy_i) |-> ##LAT valid_i, "result strobe missing")

  `AFC_CHECK(a_result_has_beat, valid_i |-> $past(start_i && !busy_i, LAT), "result without beat")

  `AFC_CHECK(a_bad_is_zero, (valid_i && bad_size_i) |-> rect_zero, "bad size result not zero")

  `AFC_CHECK(a_fields_fit, valid_i |-> rect_fits, "field wider than dimension")

endmodule

bind aspect_fit_center_rect_core afc_checker #(
  .DIM_BITS (DIM_BITS)
) u_afc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start),
  .busy_i     (busy),
  .valid_i    (valid_o),
  .pos_x_i    (pos_x_o),
  .pos_y_i    (pos_y_o),
  .out_w_i    (out_w_o),
  .out_h_i    (out_h_o),
  .bad_size_i (bad_size_o)
);
